[rtl/tlg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toroidal life grid package
// Shared types, action codes and rule constants for the life grid step unit.
// ----------------------------------------------------------------------------
package tlg_pkg;

   localparam int DEFAULT_ROWS = 32;
   localparam int DEFAULT_COLS = 32;

   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_ADVANCE = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;

   localparam logic [3:0] LIFE_BIRTH = 4'd3;
   localparam logic [3:0] LIFE_STAY  = 4'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [4:0] row;
      logic [4:0] col;
      logic       value;
   } req_type;

   typedef struct packed {
      logic       cell_value;
      logic [1:0] done_kind;
   } rsp_type;

   typedef struct packed {
      logic       shift_en;
      logic       wr_en;
      logic [4:0] wr_row;
      logic [4:0] wr_col;
      logic       wr_value;
   } cell_ctrl_type;

endpackage

[rtl/tlg_row_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toroidal life grid row cell
// Holds one grid row, takes single-cell writes and shifts along the row ring.
// ----------------------------------------------------------------------------
module tlg_row_cell
   import tlg_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int COLS  = DEFAULT_COLS
) (
   input  logic            clock,
   input  logic            reset,
   input  cell_ctrl_type   ctrl,
   input  logic [COLS-1:0] shift_in,
   output logic [COLS-1:0] row_q
);

   logic [COLS-1:0] row_ff;
   logic [COLS-1:0] row_in;

   always_comb begin
      row_in = row_ff;
      if (ctrl.shift_en) begin
         row_in = shift_in;
      end else if (ctrl.wr_en && (int'(ctrl.wr_row) == INDEX)) begin
         for (int j = 0; j < COLS; j++) begin
            if (int'(ctrl.wr_col) == j) begin
               row_in[j] = ctrl.wr_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_q = row_ff;

endmodule

[rtl/tlg_rule.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toroidal life grid rule
// Computes the next generation of one row from that row and the rows above and below it.
// ----------------------------------------------------------------------------
module tlg_rule
   import tlg_pkg::*;
#(
   parameter int COLS = DEFAULT_COLS
) (
   input  logic [COLS-1:0] above,
   input  logic [COLS-1:0] mid,
   input  logic [COLS-1:0] below,
   output logic [COLS-1:0] next_row
);

   for (genvar j = 0; j < COLS; j++) begin : g_col
      localparam int LEFT  = (j + COLS - 1) % COLS;
      localparam int RIGHT = (j + 1) % COLS;
      logic [3:0] count;

      assign count = 4'(above[LEFT]) + 4'(above[j]) + 4'(above[RIGHT])
                   + 4'(mid[LEFT]) + 4'(mid[RIGHT])
                   + 4'(below[LEFT]) + 4'(below[j]) + 4'(below[RIGHT]);

      assign next_row[j] = (count == LIFE_BIRTH) || (mid[j] && (count == LIFE_STAY));
   end

endmodule

[rtl/toroidal_life_grid_step_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toroidal life grid step unit
// A ROWS by COLS life grid on a torus, kept in a ring of row cells.
//
// Requests arrive on the req_ channel as valid/ready transfers and each one
// yields exactly one transfer on the rsp_ channel, in order. A write sets or
// clears one cell; a read returns one cell; an advance steps the grid one
// generation. Cells outside the grid are ignored on write and read as 0.
// A write goes from idle to the finish state, which loads rsp_valid. An advance
// or a read first passes through the run state, where the row ring rotates
// once through its head cell, one row per cycle, while the rule logic sees a
// three-row window. The next request can be accepted in the same cycle that
// rsp_valid rises.
// A new request is accepted only while the unit is idle, even while a
// finished response is still waiting in the output register. If the
// receiver stalls, the following result waits inside the unit and no further
// request is accepted until the output register frees up.
// Synchronous reset clears every cell to dead and drops any pending response.
// ----------------------------------------------------------------------------
module toroidal_life_grid_step_unit
   import tlg_pkg::*;
#(
   parameter int ROWS = DEFAULT_ROWS,
   parameter int COLS = DEFAULT_COLS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(ROWS);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_RUN    = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   req_type         op_ff, op_in;
   logic [COLS-1:0] prev_ff, prev_in;
   logic [COLS-1:0] first_ff, first_in;
   logic            cell_ff, cell_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic [COLS-1:0] row_q [ROWS];
   logic [COLS-1:0] tail_row;
   logic [COLS-1:0] below_row;
   logic [COLS-1:0] new_row;
   logic            last_step;
   logic            req_fire;
   logic            head_bit;
   cell_ctrl_type   ctrl;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign last_step = (cnt_ff == CNT_W'(ROWS - 1));

   assign ctrl.shift_en = (state_ff == S_RUN);
   assign ctrl.wr_en    = req_fire && (req_data.action == ACT_WRITE);
   assign ctrl.wr_row   = req_data.row;
   assign ctrl.wr_col   = req_data.col;
   assign ctrl.wr_value = req_data.value;

   assign below_row = last_step ? first_ff : row_q[1];
   assign tail_row  = (op_ff.action == ACT_ADVANCE) ? new_row : row_q[0];

   tlg_rule #(
      .COLS(COLS)
   ) u_rule (
      .above   (prev_ff),
      .mid     (row_q[0]),
      .below   (below_row),
      .next_row(new_row)
   );

   for (genvar i = 0; i < ROWS; i++) begin : g_cell
      logic [COLS-1:0] shift_in;
      if (i == ROWS - 1) begin : g_tail
         assign shift_in = tail_row;
      end else begin : g_body
         assign shift_in = row_q[i + 1];
      end

      tlg_row_cell #(
         .INDEX(i),
         .COLS (COLS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .shift_in(shift_in),
         .row_q   (row_q[i])
      );
   end

   always_comb begin
      head_bit = 1'b0;
      for (int j = 0; j < COLS; j++) begin
         if (int'(op_ff.col) == j) begin
            head_bit = row_q[0][j];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_data;
               cell_in  = 1'b0;
               cnt_in   = '0;
               prev_in  = row_q[ROWS - 1];
               first_in = row_q[0];
               if ((req_data.action == ACT_ADVANCE) || (req_data.action == ACT_READ)) begin
                  state_in = S_RUN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_RUN: begin
            prev_in = row_q[0];
            cnt_in  = cnt_ff + CNT_W'(1);
            if ((op_ff.action == ACT_READ) && (int'(cnt_ff) == int'(op_ff.row))) begin
               cell_in = head_bit;
            end
            if (last_step) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.cell_value = cell_ff;
               rsp_data_in.done_kind  = op_ff.action;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      prev_ff     <= prev_in;
      first_ff    <= first_in;
      cell_ff     <= cell_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toroidal life grid step unit testbench
// Drives writes, reads, advances and unused action codes into the grid unit.
// A scoreboard keeps its own copy of the grid, steps it on every advance and
// checks each response in order. A short directed part covers reset state,
// edge wrap and the unused action code. Random episodes then seed patches of
// the torus, advance them and read back around them. Both channels idle at
// random, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
   import tlg_pkg::*;

   localparam int GRID_ROWS = DEFAULT_ROWS;
   localparam int GRID_COLS = DEFAULT_COLS;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int REQUEST_TARGET = 1150;
   localparam int HOLD_AFTER = 300;
   localparam int HOLD_CYCLES = 500;

   class grid_scoreboard;
      logic [GRID_COLS-1:0] grid [GRID_ROWS];
      rsp_type due_replies [$];
      int errors;
      int replies_seen;

      function new();
         foreach (grid[r]) grid[r] = '0;
         errors = 0;
         replies_seen = 0;
      endfunction

      function void next_generation();
         logic [GRID_COLS-1:0] next_grid [GRID_ROWS];
         int neighbors;
         for (int r = 0; r < GRID_ROWS; r++) begin
            for (int c = 0; c < GRID_COLS; c++) begin
               neighbors = 0;
               for (int dr = -1; dr <= 1; dr++) begin
                  for (int dc = -1; dc <= 1; dc++) begin
                     if (dr != 0 || dc != 0) begin
                        neighbors += grid[(r + dr + GRID_ROWS) % GRID_ROWS]
                                         [(c + dc + GRID_COLS) % GRID_COLS];
                     end
                  end
               end
               if (grid[r][c]) begin
                  next_grid[r][c] = (neighbors == LIFE_STAY) || (neighbors == LIFE_BIRTH);
               end else begin
                  next_grid[r][c] = (neighbors == LIFE_BIRTH);
               end
            end
         end
         grid = next_grid;
      endfunction

      function void note_request(req_type item);
         rsp_type reply;
         logic on_grid;
         on_grid = (item.row < GRID_ROWS) && (item.col < GRID_COLS);
         reply.cell_value = 1'b0;
         reply.done_kind = item.action;
         case (item.action)
            ACT_WRITE: begin
               if (on_grid) grid[item.row][item.col] = item.value;
            end
            ACT_ADVANCE: begin
               next_generation();
            end
            ACT_READ: begin
               if (on_grid) reply.cell_value = grid[item.row][item.col];
            end
            default: begin
            end
         endcase
         due_replies = {due_replies, reply};
      endfunction

      task report_mismatch(input string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_response(input rsp_type got);
         rsp_type want;
         replies_seen++;
         if (due_replies.size() == 0) begin
            report_mismatch($sformatf("response %0d with nothing pending", replies_seen));
         end else begin
            want = due_replies.pop_front();
            if (got.cell_value !== want.cell_value) begin
               report_mismatch($sformatf("response %0d cell_value %b, wanted %b",
                                         replies_seen, got.cell_value, want.cell_value));
            end
            if (got.done_kind !== want.done_kind) begin
               report_mismatch($sformatf("response %0d done_kind %0d, wanted %0d",
                                         replies_seen, got.done_kind, want.done_kind));
            end
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   grid_scoreboard board = new();
   int requests_sent = 0;
   int idle_pct = 0;
   int send_gap = 0;

   toroidal_life_grid_step_unit #(
      .ROWS(GRID_ROWS),
      .COLS(GRID_COLS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function logic [4:0] wrap_row(int r);
      return 5'(((r % GRID_ROWS) + GRID_ROWS) % GRID_ROWS);
   endfunction

   function logic [4:0] wrap_col(int c);
      return 5'(((c % GRID_COLS) + GRID_COLS) % GRID_COLS);
   endfunction

   task send_request(input req_type item);
      if (send_gap > 0) begin
         req_valid <= 1'b0;
         repeat (send_gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(item);
      requests_sent++;
      send_gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
   endtask

   task send_op(input logic [1:0] action, input logic [4:0] row, input logic [4:0] col,
                input logic value);
      req_type item;
      item.action = action;
      item.row = row;
      item.col = col;
      item.value = value;
      send_request(item);
   endtask

   task run_episode();
      int base_r;
      int base_c;
      int span;
      int kind;
      base_r = $urandom_range(0, GRID_ROWS - 1);
      base_c = $urandom_range(0, GRID_COLS - 1);
      span = $urandom_range(3, 7);
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 2))
         0: idle_pct = 0;
         1: idle_pct = 15;
         default: idle_pct = 40;
      endcase
      if (kind == 0) begin
         repeat ($urandom_range(3, 6)) begin
            send_op(2'($urandom_range(0, 3)), 5'($urandom), 5'($urandom), 1'($urandom));
         end
      end else if (kind == 1) begin
         repeat ($urandom_range(4, 12)) begin
            send_op(ACT_WRITE, wrap_row(base_r + $urandom_range(0, span - 1)),
                    wrap_col(base_c + $urandom_range(0, span - 1)), 1'b0);
         end
      end else begin
         repeat ($urandom_range(4, 14)) begin
            send_op(ACT_WRITE, wrap_row(base_r + $urandom_range(0, span - 1)),
                    wrap_col(base_c + $urandom_range(0, span - 1)),
                    $urandom_range(0, 9) < 6);
         end
         repeat ($urandom_range(1, 3)) begin
            send_op(ACT_ADVANCE, 5'($urandom), 5'($urandom), 1'($urandom));
            repeat ($urandom_range(1, 4)) begin
               send_op(ACT_READ, wrap_row(base_r - 1 + $urandom_range(0, span + 1)),
                       wrap_col(base_c - 1 + $urandom_range(0, span + 1)), 1'($urandom));
            end
         end
      end
   endtask

   initial begin
      int stall_left;
      int hold_done;
      stall_left = 0;
      hold_done = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && rsp_ready) board.check_response(rsp_data);
            if (!hold_done && board.replies_seen >= HOLD_AFTER) begin
               hold_done = 1;
               rsp_ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               rsp_ready <= 1'b1;
            end else begin
               if (stall_left == 0 && $urandom_range(0, 99) < idle_pct) stall_left = pick_gap();
               if (stall_left > 0) begin
                  rsp_ready <= 1'b0;
                  stall_left--;
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: reset state, a blinker that wraps rows and then columns,
      // ignored fields on an advance, and the unused action code.
      send_op(ACT_READ, 5'd31, 5'd31, 1'b0);
      send_op(ACT_READ, 5'd0, 5'd0, 1'b1);
      send_op(ACT_WRITE, 5'd31, 5'd0, 1'b1);
      send_op(ACT_WRITE, 5'd0, 5'd0, 1'b1);
      send_op(ACT_WRITE, 5'd1, 5'd0, 1'b1);
      send_op(ACT_UNUSED, 5'd31, 5'd31, 1'b1);
      send_op(ACT_ADVANCE, 5'd31, 5'd31, 1'b1);
      send_op(ACT_READ, 5'd0, 5'd31, 1'b0);
      send_op(ACT_READ, 5'd31, 5'd0, 1'b0);
      send_op(ACT_READ, 5'd0, 5'd1, 1'b0);
      send_op(ACT_ADVANCE, 5'd0, 5'd0, 1'b0);
      send_op(ACT_READ, 5'd31, 5'd0, 1'b1);
      send_op(ACT_READ, 5'd0, 5'd31, 1'b1);
      send_op(ACT_WRITE, 5'd31, 5'd31, 1'b1);
      send_op(ACT_READ, 5'd31, 5'd31, 1'b0);
      send_op(ACT_WRITE, 5'd31, 5'd31, 1'b0);
      send_op(ACT_READ, 5'd31, 5'd31, 1'b1);
      send_op(ACT_UNUSED, 5'd0, 5'd0, 1'b0);
      send_op(ACT_ADVANCE, 5'd15, 5'd16, 1'b0);
      send_op(ACT_READ, 5'd1, 5'd0, 1'b0);

      while (requests_sent < REQUEST_TARGET) run_episode();
      req_valid <= 1'b0;

      while (board.due_replies.size() != 0) @(posedge clock);
      repeat (GRID_ROWS + 10) @(posedge clock);
      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

[toroidal_life_grid_step_unit.f]
rtl/tlg_pkg.sv
rtl/tlg_row_cell.sv
rtl/tlg_rule.sv
rtl/toroidal_life_grid_step_unit.sv
bench/testbench.sv
